>>> hdl/sh13_pkg.sv
// ----------------------------------------------------------------------------
// sh13_pkg
// Shared types, constants and round functions of the SipHash-1-3 stream hash.
// ----------------------------------------------------------------------------
package sh13_pkg;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;
    localparam int          SIP_LEN_SHIFT = 56;

    localparam int          CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic [3:0]  FULL_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } lanes_t;

    typedef struct packed {
        logic        restart;
        logic [63:0] low;
        logic [63:0] high;
    } key_t;

    typedef struct packed {
        lanes_t      lanes;
        logic [63:0] block;
    } fin_req_t;

    typedef struct packed {
        logic [3:0]  stage_v;
        logic        out_v;
    } fin_status_t;

    function automatic lanes_t lanes_init(logic [63:0] k0, logic [63:0] k1);
        lanes_t l;
        l.a = k0 ^ SIP_C0;
        l.b = k1 ^ SIP_C1;
        l.c = k0 ^ SIP_C2;
        l.d = k1 ^ SIP_C3;
        return l;
    endfunction

    function automatic lanes_t sip_round(lanes_t l);
        lanes_t r;
        r = l;
        r.a = r.a + r.b;
        r.c = r.c + r.d;
        r.b = {r.b[50:0], r.b[63:51]} ^ r.a;
        r.d = {r.d[47:0], r.d[63:48]} ^ r.c;
        r.a = {r.a[31:0], r.a[63:32]};
        r.c = r.c + r.b;
        r.a = r.a + r.d;
        r.b = {r.b[46:0], r.b[63:47]} ^ r.c;
        r.d = {r.d[42:0], r.d[63:43]} ^ r.a;
        r.c = {r.c[31:0], r.c[63:32]};
        return r;
    endfunction

    function automatic lanes_t absorb_word(lanes_t l, logic [63:0] m);
        lanes_t r;
        r = l;
        r.d = r.d ^ m;
        r = sip_round(r);
        r.a = r.a ^ m;
        return r;
    endfunction

endpackage

>>> hdl/sh13_absorb.sv
// ----------------------------------------------------------------------------
// sh13_absorb
// Input register, lane state and length count; one round per full word and
// hand-off of the final block to the finalisation pipeline.
// ----------------------------------------------------------------------------
module sh13_absorb
(
    input  logic              clk,
    input  logic              rst_n,
    input  sh13_pkg::key_t    key,
    input  logic              msg_valid,
    output logic              msg_stall,
    input  logic [63:0]       message_word,
    input  logic [3:0]        valid_bytes,
    input  logic              last_word,
    output logic              fin_valid,
    input  logic              fin_ready,
    output sh13_pkg::fin_req_t fin_req,
    output logic              held
);
    import sh13_pkg::*;

    logic        s0_valid_reg;
    logic [63:0] s0_word_reg;
    logic [3:0]  s0_bytes_reg;
    logic        s0_last_reg;
    lanes_t      lanes_reg;
    lanes_t      lanes_next;
    logic [7:0]  length_reg;
    logic [7:0]  length_next;

    logic        fire;
    logic        s0_ready;
    logic        accept;
    logic        full;
    lanes_t      absorbed;
    logic [63:0] tail;
    logic [7:0]  length_total;

    assign fire      = s0_valid_reg && (!s0_last_reg || fin_ready);
    assign s0_ready  = !s0_valid_reg || fire;
    assign msg_stall = !s0_ready;
    assign accept    = msg_valid && s0_ready;
    assign held      = s0_valid_reg;

    assign full     = (s0_bytes_reg >= FULL_BYTES);
    assign absorbed = absorb_word(lanes_reg, s0_word_reg);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail[8*i +: 8] = (!full && (4'(i) < s0_bytes_reg)) ? s0_word_reg[8*i +: 8] : 8'h00;
        end
    end

    assign length_total = full ? (length_reg + 8'd8) : (length_reg + {4'h0, s0_bytes_reg});

    assign fin_valid     = s0_valid_reg && s0_last_reg;
    assign fin_req.lanes = full ? absorbed : lanes_reg;
    assign fin_req.block = (64'(length_total) << SIP_LEN_SHIFT) | tail;

    always_comb
    begin
        lanes_next  = lanes_reg;
        length_next = length_reg;
        if (key.restart)
        begin
            lanes_next  = lanes_init(key.low, key.high);
            length_next = 8'h00;
        end
        else if (fire && s0_last_reg)
        begin
            lanes_next  = lanes_init(key.low, key.high);
            length_next = 8'h00;
        end
        else if (fire)
        begin
            lanes_next  = absorbed;
            length_next = length_reg + 8'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            lanes_reg    <= lanes_init(64'h0, 64'h0);
            length_reg   <= 8'h00;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= msg_valid;
            end
            lanes_reg  <= lanes_next;
            length_reg <= length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_word_reg  <= message_word;
            s0_bytes_reg <= valid_bytes;
            s0_last_reg  <= last_word;
        end
    end

endmodule

>>> hdl/sh13_final.sv
// ----------------------------------------------------------------------------
// sh13_final
// Finalisation pipeline: final block round, three closing rounds, digest
// fold and the result register.
// ----------------------------------------------------------------------------
module sh13_final
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fin_valid,
    output logic                  fin_ready,
    input  sh13_pkg::fin_req_t    fin_req,
    output logic                  hash_valid,
    input  logic                  hash_stall,
    output logic [63:0]           hash_value,
    output sh13_pkg::fin_status_t status
);
    import sh13_pkg::*;

    logic [3:0]  stage_v_reg;
    lanes_t      stage_lanes_reg [4];
    logic [63:0] block_reg;
    logic        out_v_reg;
    logic [63:0] hash_reg;

    logic [3:0]  rdy;
    logic        out_ready;
    lanes_t      step1;
    lanes_t      step2;
    lanes_t      step3;
    lanes_t      step_out;
    logic [63:0] digest;

    assign out_ready = !out_v_reg || !hash_stall;
    assign rdy[3]    = !stage_v_reg[3] || out_ready;
    assign rdy[2]    = !stage_v_reg[2] || rdy[3];
    assign rdy[1]    = !stage_v_reg[1] || rdy[2];
    assign rdy[0]    = !stage_v_reg[0] || rdy[1];
    assign fin_ready = rdy[0];

    always_comb
    begin
        step1   = absorb_word(stage_lanes_reg[0], block_reg);
        step1.c = step1.c ^ SIP_FINAL_XOR;
    end

    assign step2    = sip_round(stage_lanes_reg[1]);
    assign step3    = sip_round(stage_lanes_reg[2]);
    assign step_out = sip_round(stage_lanes_reg[3]);
    assign digest   = step_out.a ^ step_out.b ^ step_out.c ^ step_out.d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 4'h0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                stage_v_reg[0] <= fin_valid;
            end
            if (rdy[1])
            begin
                stage_v_reg[1] <= stage_v_reg[0];
            end
            if (rdy[2])
            begin
                stage_v_reg[2] <= stage_v_reg[1];
            end
            if (rdy[3])
            begin
                stage_v_reg[3] <= stage_v_reg[2];
            end
            if (out_ready)
            begin
                out_v_reg <= stage_v_reg[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && fin_valid)
        begin
            stage_lanes_reg[0] <= fin_req.lanes;
            block_reg          <= fin_req.block;
        end
        if (rdy[1] && stage_v_reg[0])
        begin
            stage_lanes_reg[1] <= step1;
        end
        if (rdy[2] && stage_v_reg[1])
        begin
            stage_lanes_reg[2] <= step2;
        end
        if (rdy[3] && stage_v_reg[2])
        begin
            stage_lanes_reg[3] <= step3;
        end
        if (out_ready && stage_v_reg[3])
        begin
            hash_reg <= digest;
        end
    end

    assign hash_valid     = out_v_reg;
    assign hash_value     = hash_reg;
    assign status.stage_v = stage_v_reg;
    assign status.out_v   = out_v_reg;

endmodule

>>> hdl/siphash13_stream_hash.sv
// ----------------------------------------------------------------------------
// siphash13_stream_hash
// SipHash-1-3 digest of a byte message streamed as little-endian 64-bit words.
//
// Usage:
//   message channel (msg_valid / msg_stall) carries message_word, valid_bytes
//   and last_word; a request is taken when msg_valid is high and msg_stall low.
//   One word is taken every cycle while msg_stall is low; each full word costs
//   one SipRound in the lane update loop.
//   A last word hands its lanes and final block to a four stage finalisation
//   pipeline (block round, three closing rounds) and the fold to the result
//   register: hash_valid rises once the folded digest is written to it.
//   Several message ends may be in flight at once; the first word of the next
//   message may be taken as a last word is handed to the finalisation pipeline.
//   A stall on the hash channel holds the result; empty stages still fill,
//   and msg_stall rises only once the whole pipeline is occupied.
//   Config channel (cfg_valid / cfg_ready) writes key_low at index 0 and
//   key_high at index 1; other indexes are ignored. A key write restarts the
//   message; write only while the block is idle.
//   Reset clears both keys, the length count and all valid flags.
// ----------------------------------------------------------------------------
module siphash13_stream_hash
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sh13_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             msg_valid,
    output logic                             msg_stall,
    input  logic [63:0]                      message_word,
    input  logic [3:0]                       valid_bytes,
    input  logic                             last_word,
    output logic                             hash_valid,
    input  logic                             hash_stall,
    output logic [63:0]                      hash_value
);
    import sh13_pkg::*;

    logic [63:0] key_low_reg;
    logic [63:0] key_low_next;
    logic [63:0] key_high_reg;
    logic [63:0] key_high_next;
    logic        cfg_we;
    key_t        key;
    logic        fin_valid;
    logic        fin_ready;
    fin_req_t    fin_req;
    fin_status_t fin_status;
    logic        held;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        key.restart   = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:
                begin
                    key_low_next = cfg_data;
                    key.restart  = 1'b1;
                end
                REG_KEY_HIGH:
                begin
                    key_high_next = cfg_data;
                    key.restart   = 1'b1;
                end
                default:
                begin
                    key.restart = 1'b0;
                end
            endcase
        end
        key.low  = key_low_next;
        key.high = key_high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= 64'h0;
            key_high_reg <= 64'h0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    sh13_absorb u_absorb
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .fin_valid    (fin_valid),
        .fin_ready    (fin_ready),
        .fin_req      (fin_req),
        .held         (held)
    );

    sh13_final u_final
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin_ready  (fin_ready),
        .fin_req    (fin_req),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .hash_value (hash_value),
        .status     (fin_status)
    );

    // a message end handed over lands in the first finalisation stage
    a_fin_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && fin_ready |=> fin_status.stage_v[0])
        else $error("final block lost at hand-off");

    // a stalled result keeps the stage behind it occupied
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && hash_stall && fin_status.stage_v[3] |=> fin_status.stage_v[3])
        else $error("finalisation stage dropped under stall");

    // input is held off only while items sit in the input register and the first finalisation stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        msg_stall |-> held && fin_status.stage_v[0])
        else $error("message stalled with free input register");

endmodule
